// ===== sv/contact_direction_to_spherical_top_assert.svh =====
// Assertion macros for the contact direction to spherical readout.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef CONTACT_DIRECTION_TO_SPHERICAL_TOP_ASSERT_SVH
`define CONTACT_DIRECTION_TO_SPHERICAL_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// Consequent must hold in the cycle after the antecedent.
`define CDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

// ===== sv/cds_pkg.sv =====
// Shared types, constants and helper functions for the contact readout.
// No dependencies; used by the top level.
package cds_pkg;

    localparam int EVAL_STEPS_DEF = 1024;
    localparam int FRAC_BITS      = 16;
    localparam int VW             = 59;   // accumulator width of the direction vector
    localparam int CW             = 34;   // CORDIC datapath width
    localparam int SQW            = 50;   // square root datapath width

    localparam logic [16:0] FIX_ONE_17 = 17'(1 << FRAC_BITS);
    localparam logic [16:0] HALF_17    = 17'(1 << (FRAC_BITS - 1));

    localparam logic signed [CW-1:0] PRE_LIMIT  = CW'(1 << 29);
    localparam logic signed [34:0]   THETA_CUT  = 35'sd3417827;
    localparam logic signed [34:0]   HALF_TURN  = 35'sd2147483648;
    localparam logic signed [CW-1:0] QUARTER_TURN = CW'(1 << 30);
    localparam logic signed [34:0]   ELEV_RND   = 35'sd1 <<< (30 - FRAC_BITS);
    localparam int                   ELEV_SHIFT = 31 - FRAC_BITS;
    localparam logic signed [34:0]   AZIM_RND   = 35'sd1 <<< (31 - FRAC_BITS);
    localparam int                   AZIM_SHIFT = 32 - FRAC_BITS;
    localparam logic [32:0]          NEAR_X_GAIN = 33'd200;
    localparam logic [SQW-1:0]       SQRT_TOP_BIT = SQW'(1) << 48;

    // Sequencer step counts
    localparam int DIV_STEPS   = 16;
    localparam int ROT_LAST    = 9;
    localparam int SQ_LAST     = 5;
    localparam int SQRT_LAST   = 24;
    localparam int CORDIC_LAST = 29;

    // Request kinds and row selector
    localparam logic [1:0] REQ_ROW     = 2'd0;
    localparam logic [1:0] REQ_CENTER  = 2'd1;
    localparam logic [1:0] REQ_CONTACT = 2'd2;
    localparam logic [1:0] ROW_NONE    = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_CMP, ST_DIV, ST_DIFF, ST_RED, ST_ROT,
        ST_SQ, ST_SQRT, ST_TSET, ST_NORM, ST_ITER, ST_PSEL, ST_WRITE, ST_OUT
    } state_t;

    // One stored reading; range sits in the low bits.
    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
        logic [16:0] azim;
        logic [16:0] elev;
        logic [16:0] rng;
    } entry_t;

    localparam entry_t CLEAR_ENTRY = '{blue: 16'd0, green: 16'd0, red: 16'd0,
                                       azim: HALF_17, elev: HALF_17, rng: 17'd0};

    function automatic logic [VW-1:0] mag_vw(input logic signed [VW-1:0] v);
        return v[VW-1] ? VW'(-v) : VW'(v);
    endfunction

    function automatic logic [CW-1:0] mag_cw(input logic signed [CW-1:0] v);
        return v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    // Arctangent of 2^-i in units of 2^32 per turn.
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/contact_direction_to_spherical_top.sv =====
// Top level of the proximity sensor contact readout.
// Depends on cds_pkg, cds_ram and contact_direction_to_spherical_top_assert.svh.
//
// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+-------------------------------------------
// s_*       | in  | s_tvalid/s_tready  | pose or contact item (tdata, tuser)
// m_*       | out | m_tvalid/m_tready  | readings of one contact (tdata, tuser)
// cfg_*     | in  | cfg_valid/cfg_ready| sensor_radius write (cfg_data)
//
// After reset a clearing pass over all EVAL_STEPS entries initializes the reading store;
// configuration writes are taken during it, input transactions are not.
// The work on an updated contact is the division, the square root loop, the one
// or two passes of the shared CORDIC unit with their normalization shifts, and the
// vector reduction shifts.
// The input is not ready while a contact is in work; a finished result sits in the
// output register, so the next item is taken while it waits for m_tready.
module contact_direction_to_spherical_top #(
    parameter int EVAL_STEPS = cds_pkg::EVAL_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // tdata: step_index[9:0], depth[40:10], vec_x[72:41], vec_y[104:73],
    //        vec_z[136:105], hit_present[137], hit_red[153:138],
    //        hit_green[169:154], hit_blue[185:170], zero fill to 191
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic [3:0]   s_tuser,     // req_type[1:0], row_index[3:2]
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: range_frac[16:0], elevation_frac[33:17], azimuth_frac[50:34],
    //        out_red[66:51], out_green[82:67], out_blue[98:83], zero fill to 103
    output logic [103:0] m_tdata,
    output logic         m_tuser,     // updated
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [30:0]  cfg_data     // sensor_radius
);
    import cds_pkg::*;

    localparam int AW = EVAL_STEPS > 1 ? $clog2(EVAL_STEPS) : 1;

    // Input field unpacking
    logic [1:0]  s_req, s_row;
    logic [9:0]  s_step;
    logic [30:0] s_depth;
    logic signed [31:0] s_vec [3];
    logic        s_hit;
    logic [47:0] s_color;

    assign s_req     = s_tuser[1:0];
    assign s_row     = s_tuser[3:2];
    assign s_step    = s_tdata[9:0];
    assign s_depth   = s_tdata[40:10];
    assign s_vec[0]  = s_tdata[72:41];
    assign s_vec[1]  = s_tdata[104:73];
    assign s_vec[2]  = s_tdata[136:105];
    assign s_hit     = s_tdata[137];
    assign s_color   = s_tdata[185:138];

    // Control and configuration state
    state_t state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic        m_valid_reg, m_valid_next;
    logic signed [31:0] rot_reg [3][3];
    logic signed [31:0] rot_next [3][3];
    logic signed [31:0] ctr_reg [3];
    logic signed [31:0] ctr_next [3];
    logic [30:0] radius_reg, radius_next;

    // Item and working registers
    logic [9:0]  step_reg, step_next;
    logic [30:0] depth_reg, depth_next;
    logic signed [31:0] p_reg [3];
    logic signed [31:0] p_next [3];
    logic        hit_reg, hit_next;
    logic [47:0] color_reg, color_next;
    logic        pass_reg, pass_next;
    logic [32:0] rem_reg, rem_next;
    logic [15:0] q_reg, q_next;
    logic [16:0] rng_reg, rng_next;
    logic signed [VW-1:0] v_reg [3];
    logic signed [VW-1:0] v_next [3];
    logic signed [24:0]   d_reg [3];
    logic signed [24:0]   d_next [3];
    logic [1:0]  ri_reg, ri_next, rj_reg, rj_next, ai_reg, ai_next;
    logic [47:0] xx_reg, xx_next, yy_reg, yy_next, zz_reg, zz_next;
    logic [63:0] tt_reg, tt_next;
    logic [SQW-1:0] sq_n_reg, sq_n_next, sq_res_reg, sq_res_next, sq_bit_reg, sq_bit_next;
    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic        sel_reg, sel_next;
    logic signed [CW-1:0] zt_reg, zt_next, zp_reg, zp_next;
    logic        res_upd_reg, res_upd_next;
    entry_t      res_entry_reg, res_entry_next;
    logic        m_user_reg, m_user_next;
    entry_t      m_entry_reg, m_entry_next;

    // Shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p_reg, mul_p_next;

    // Reading store
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t        ram_wdata, ram_rdata;

    cds_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (EVAL_STEPS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Conditions shared by the sequencer and the datapath
    logic [VW-1:0] vmag [3];
    logic red_big_c, skip_c, div_big_c, radius_zero_c, step_bad_c;
    logic cz_zero_c, c_small_c, low_c, near_c, out_free_c;
    logic signed [34:0] zt_ext, turn_gap;
    logic [SQW-1:0] sum_xyz;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vmag[i] = mag_vw(v_reg[i]);
        end
    end

    assign red_big_c = (vmag[0][VW-1:24] != '0) || (vmag[1][VW-1:24] != '0)
                    || (vmag[2][VW-1:24] != '0);
    assign skip_c = {19'd0, depth_reg, 16'd0} < 66'(mul_p_reg);
    assign div_big_c = {1'b0, depth_reg} >= {radius_reg, 1'b0};
    assign radius_zero_c = (radius_reg == '0);
    assign step_bad_c = 32'(s_step) >= 32'(EVAL_STEPS);
    assign cz_zero_c = (cx_reg == '0) && (cy_reg == '0);
    assign c_small_c = (mag_cw(cx_reg) < CW'(PRE_LIMIT)) && (mag_cw(cy_reg) < CW'(PRE_LIMIT));
    assign zt_ext = 35'(cz_reg);
    assign turn_gap = HALF_TURN - zt_ext;
    assign low_c = (zt_ext < THETA_CUT) || (turn_gap < THETA_CUT);
    assign sum_xyz = SQW'(xx_reg) + SQW'(yy_reg) + SQW'(zz_reg);
    assign near_c = tt_reg < 64'(sum_xyz);
    assign out_free_c = !m_valid_reg || m_tready;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_addr_reg == AW'(EVAL_STEPS - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (s_tvalid && s_req == REQ_CONTACT)
                    state_next = step_bad_c ? ST_OUT : ST_READ;
            ST_READ:
                state_next = ST_CMP;
            ST_CMP:
            begin
                priority if (skip_c) state_next = ST_OUT;
                else if (radius_zero_c || div_big_c) state_next = ST_DIFF;
                else state_next = ST_DIV;
            end
            ST_DIV:
                if (cnt_reg == 6'(DIV_STEPS - 1)) state_next = ST_DIFF;
            ST_DIFF:
                state_next = ST_RED;
            ST_RED:
                if (!red_big_c) state_next = pass_reg ? ST_SQ : ST_ROT;
            ST_ROT:
                if (cnt_reg == 6'(ROT_LAST)) state_next = ST_RED;
            ST_SQ:
                if (cnt_reg == 6'(SQ_LAST)) state_next = ST_SQRT;
            ST_SQRT:
                if (cnt_reg == 6'(SQRT_LAST)) state_next = ST_TSET;
            ST_TSET:
                state_next = ST_NORM;
            ST_NORM:
            begin
                priority if (cz_zero_c) state_next = sel_reg ? ST_WRITE : ST_PSEL;
                else if (!c_small_c) state_next = ST_ITER;
                else state_next = ST_NORM;
            end
            ST_ITER:
                if (cnt_reg == 6'(CORDIC_LAST)) state_next = sel_reg ? ST_WRITE : ST_PSEL;
            ST_PSEL:
                state_next = (low_c || near_c) ? ST_WRITE : ST_NORM;
            ST_WRITE:
                state_next = ST_OUT;
            ST_OUT:
                if (out_free_c) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and store control
    logic [33:0] rem2;
    logic [33:0] dvs2;
    logic        div_ge;
    logic [SQW-1:0] sq_sum;
    logic signed [CW-1:0] xs, ys, at;
    logic signed [CW-1:0] zp_use;
    logic signed [34:0] elev_sum, azim_sum;
    entry_t      wr_entry;

    always_comb
    begin
        cnt_next = cnt_reg;
        clr_addr_next = clr_addr_reg;
        m_valid_next = m_valid_reg;
        rot_next = rot_reg;
        ctr_next = ctr_reg;
        radius_next = radius_reg;
        step_next = step_reg;
        depth_next = depth_reg;
        p_next = p_reg;
        hit_next = hit_reg;
        color_next = color_reg;
        pass_next = pass_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        rng_next = rng_reg;
        v_next = v_reg;
        d_next = d_reg;
        ri_next = ri_reg;
        rj_next = rj_reg;
        ai_next = ai_reg;
        xx_next = xx_reg;
        yy_next = yy_reg;
        zz_next = zz_reg;
        tt_next = tt_reg;
        sq_n_next = sq_n_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        sel_next = sel_reg;
        zt_next = zt_reg;
        zp_next = zp_reg;
        res_upd_next = res_upd_reg;
        res_entry_next = res_entry_reg;
        m_user_next = m_user_reg;
        m_entry_next = m_entry_reg;
        mul_a = '0;
        mul_b = '0;
        ram_we = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = CLEAR_ENTRY;
        ram_re = 1'b0;
        ram_raddr = AW'(s_step);
        rem2 = {rem_reg, 1'b0};
        dvs2 = {2'b0, radius_reg, 1'b0};
        div_ge = rem2 >= dvs2;
        sq_sum = sq_res_reg + sq_bit_reg;
        xs = cx_reg >>> cnt_reg;
        ys = cy_reg >>> cnt_reg;
        at = CW'({2'b0, atan_entry(cnt_reg[4:0])});
        zp_use = sel_reg ? cz_reg : zp_reg;
        elev_sum = 35'(zt_reg) + ELEV_RND;
        azim_sum = HALF_TURN + 35'(zp_use) + AZIM_RND;
        wr_entry.rng = rng_reg;
        wr_entry.elev = 17'(elev_sum >>> ELEV_SHIFT);
        wr_entry.azim = 17'(azim_sum >> AZIM_SHIFT);
        wr_entry.red = hit_reg ? color_reg[15:0] : 16'd0;
        wr_entry.green = hit_reg ? color_reg[31:16] : 16'd0;
        wr_entry.blue = hit_reg ? color_reg[47:32] : 16'd0;

        // Configuration write and output drain
        if (cfg_valid)
        begin
            radius_next = cfg_data;
        end
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (s_req)
                        REQ_ROW:
                            if (s_row != ROW_NONE)
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    rot_next[s_row][i] = s_vec[i];
                                end
                            end
                        REQ_CENTER:
                            ctr_next = s_vec;
                        REQ_CONTACT:
                        begin
                            step_next = s_step;
                            depth_next = s_depth;
                            p_next = s_vec;
                            hit_next = s_hit;
                            color_next = s_color;
                            ram_re = !step_bad_c;
                            res_upd_next = 1'b0;
                            res_entry_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // Stored range times radius for the skip test
                mul_a = 33'({16'd0, ram_rdata.rng});
                mul_b = 33'({2'b0, radius_reg});
            end
            ST_CMP:
            begin
                res_upd_next = 1'b0;
                res_entry_next = ram_rdata;
                rem_next = {2'b0, depth_reg};
                q_next = '0;
                cnt_next = '0;
                if (radius_zero_c)
                    rng_next = (depth_reg != '0) ? FIX_ONE_17 : 17'd0;
                else
                    rng_next = FIX_ONE_17;
            end
            ST_DIV:
            begin
                // One quotient bit per cycle
                rem_next = div_ge ? 33'(rem2 - dvs2) : rem2[32:0];
                q_next = {q_reg[14:0], div_ge};
                rng_next = {1'b0, q_reg[14:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            ST_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    v_next[i] = VW'(p_reg[i]) - VW'(ctr_reg[i]);
                end
                pass_next = 1'b0;
            end
            ST_RED:
            begin
                // Common right shift of magnitudes until all fit in 24 bits
                if (red_big_c)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        v_next[i] = v_reg[i][VW-1] ? VW'(-(vmag[i] >> 1)) : VW'(vmag[i] >> 1);
                    end
                end
                else if (!pass_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        d_next[i] = v_reg[i][24:0];
                        v_next[i] = '0;
                    end
                    ri_next = '0;
                    rj_next = '0;
                    cnt_next = '0;
                end
                else
                begin
                    cnt_next = '0;
                end
            end
            ST_ROT:
            begin
                // v[i] accumulates R[j][i] * d[j], one product a cycle
                if (cnt_reg != 6'(ROT_LAST))
                begin
                    mul_a = 33'(rot_reg[rj_reg][ri_reg]);
                    mul_b = 33'(d_reg[rj_reg]);
                    ai_next = ri_reg;
                    if (rj_reg == 2'd2)
                    begin
                        rj_next = '0;
                        ri_next = ri_reg + 1'b1;
                    end
                    else
                    begin
                        rj_next = rj_reg + 1'b1;
                    end
                end
                if (cnt_reg != '0)
                begin
                    v_next[ai_reg] = v_reg[ai_reg] + mul_p_reg[VW-1:0];
                end
                if (cnt_reg == 6'(ROT_LAST))
                begin
                    pass_next = 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_SQ:
            begin
                // Squares, then (200*|vx|)^2 for the near-zero x test
                unique case (cnt_reg)
                    6'd0:
                    begin
                        mul_a = v_reg[0][32:0];
                        mul_b = v_reg[0][32:0];
                    end
                    6'd1:
                    begin
                        mul_a = v_reg[1][32:0];
                        mul_b = v_reg[1][32:0];
                        xx_next = mul_p_reg[47:0];
                    end
                    6'd2:
                    begin
                        mul_a = v_reg[2][32:0];
                        mul_b = v_reg[2][32:0];
                        yy_next = mul_p_reg[47:0];
                    end
                    6'd3:
                    begin
                        mul_a = vmag[0][32:0];
                        mul_b = NEAR_X_GAIN;
                        zz_next = mul_p_reg[47:0];
                    end
                    6'd4:
                    begin
                        mul_a = mul_p_reg[32:0];
                        mul_b = mul_p_reg[32:0];
                    end
                    default:
                    begin
                        tt_next = mul_p_reg[63:0];
                        sq_n_next = SQW'(xx_reg) + SQW'(yy_reg);
                        sq_res_next = '0;
                        sq_bit_next = SQRT_TOP_BIT;
                    end
                endcase
                cnt_next = (cnt_reg == 6'(SQ_LAST)) ? 6'd0 : cnt_reg + 1'b1;
            end
            ST_SQRT:
            begin
                // One result bit per cycle
                if (sq_n_reg >= sq_sum)
                begin
                    sq_n_next = sq_n_reg - sq_sum;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_TSET:
            begin
                cx_next = CW'(sq_res_reg);
                cy_next = CW'(v_reg[2]);
                cz_next = '0;
                sel_next = 1'b0;
            end
            ST_NORM:
            begin
                // Scale up until one component reaches the CORDIC working range
                if (cz_zero_c)
                begin
                    cz_next = '0;
                end
                else if (c_small_c)
                begin
                    cx_next = cx_reg <<< 1;
                    cy_next = cy_reg <<< 1;
                end
                cnt_next = '0;
            end
            ST_ITER:
            begin
                if (cy_reg > 0)
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + at;
                end
                else
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - at;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_PSEL:
            begin
                // Azimuth special cases, else start the second CORDIC pass
                zt_next = cz_reg;
                priority if (low_c)
                begin
                    zp_next = '0;
                end
                else if (near_c)
                begin
                    zp_next = (v_reg[1] > 0) ? QUARTER_TURN : CW'(-QUARTER_TURN);
                end
                else
                begin
                    cx_next = CW'(vmag[0]);
                    cy_next = v_reg[0][VW-1] ? CW'(-v_reg[1]) : CW'(v_reg[1]);
                    cz_next = '0;
                    sel_next = 1'b1;
                end
            end
            ST_WRITE:
            begin
                ram_we = 1'b1;
                ram_waddr = AW'(step_reg);
                ram_wdata = wr_entry;
                res_upd_next = 1'b1;
                res_entry_next = wr_entry;
            end
            ST_OUT:
            begin
                if (out_free_c)
                begin
                    m_valid_next = 1'b1;
                    m_user_next = res_upd_reg;
                    m_entry_next = res_entry_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign mul_p_next = mul_a * mul_b;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg <= '0;
            clr_addr_reg <= '0;
            m_valid_reg <= 1'b0;
            radius_reg <= 31'd65536;
            for (int i = 0; i < 3; i++)
            begin
                ctr_reg[i] <= '0;
                for (int j = 0; j < 3; j++)
                begin
                    rot_reg[i][j] <= (i == j) ? 32'(FIX_ONE_17) : 32'd0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg <= m_valid_next;
            radius_reg <= radius_next;
            ctr_reg <= ctr_next;
            rot_reg <= rot_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        depth_reg <= depth_next;
        p_reg <= p_next;
        hit_reg <= hit_next;
        color_reg <= color_next;
        pass_reg <= pass_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        rng_reg <= rng_next;
        v_reg <= v_next;
        d_reg <= d_next;
        ri_reg <= ri_next;
        rj_reg <= rj_next;
        ai_reg <= ai_next;
        xx_reg <= xx_next;
        yy_reg <= yy_next;
        zz_reg <= zz_next;
        tt_reg <= tt_next;
        sq_n_reg <= sq_n_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
        sel_reg <= sel_next;
        zt_reg <= zt_next;
        zp_reg <= zp_next;
        res_upd_reg <= res_upd_next;
        res_entry_reg <= res_entry_next;
        m_user_reg <= m_user_next;
        m_entry_reg <= m_entry_next;
        mul_p_reg <= mul_p_next;
    end

    // Port outputs
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tuser = m_user_reg;
    assign m_tdata = {5'd0, m_entry_reg};

`include "contact_direction_to_spherical_top_assert.svh"

    // A contact transaction always leaves idle for the store read or the result.
    `CDS_ASSERT_NEXT(a_contact_starts, s_tvalid && s_tready && s_req == REQ_CONTACT, state_reg == ST_READ || state_reg == ST_OUT)
    // The direction vector fits in 24 magnitude bits before the squares.
    `CDS_ASSERT_NOW(a_reduced_before_sq, state_reg == ST_SQ && cnt_reg == 6'd0, !red_big_c)
    // A pending result is held until the output register frees up.
    `CDS_ASSERT_NEXT(a_result_waits, state_reg == ST_OUT && m_valid_reg && !m_tready, state_reg == ST_OUT && m_tvalid)
    // The divider never runs past its quotient width.
    `CDS_ASSERT_NOW(a_div_count, state_reg == ST_DIV, cnt_reg < 6'(DIV_STEPS))

endmodule

// ===== sv/cds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
